// File: rtl/alu8f_pkg.sv
// Shared types, operation codes and flag positions for the 8-bit ALU with flags.
package alu8f_pkg;

  localparam int unsigned KindW  = 5;
  localparam int unsigned WordW  = 16;
  localparam int unsigned FlagsW = 4;
  localparam int unsigned BitIdxW = 3;

  // Flag bit positions
  localparam int unsigned FlagZ = 3;
  localparam int unsigned FlagN = 2;
  localparam int unsigned FlagH = 1;
  localparam int unsigned FlagC = 0;

  typedef enum logic [KindW-1:0] {
    OP_ADD   = 5'd0,
    OP_ADC   = 5'd1,
    OP_SUB   = 5'd2,
    OP_SBC   = 5'd3,
    OP_AND   = 5'd4,
    OP_XOR   = 5'd5,
    OP_OR    = 5'd6,
    OP_CP    = 5'd7,
    OP_INC   = 5'd8,
    OP_DEC   = 5'd9,
    OP_ADD16 = 5'd10,
    OP_RLC   = 5'd11,
    OP_RRC   = 5'd12,
    OP_RL    = 5'd13,
    OP_RR    = 5'd14,
    OP_SLA   = 5'd15,
    OP_SRA   = 5'd16,
    OP_SWAP  = 5'd17,
    OP_SRL   = 5'd18,
    OP_BIT   = 5'd19
  } alu_op_e;

  typedef struct packed {
    logic [KindW-1:0]   kind;
    logic [WordW-1:0]   operand_a;
    logic [WordW-1:0]   operand_b;
    logic [FlagsW-1:0]  flags_in;
    logic [BitIdxW-1:0] bit_index;
  } alu_in_t;

  typedef struct packed {
    logic [WordW-1:0]  result;
    logic [FlagsW-1:0] flags_out;
  } alu_out_t;

endpackage

// File: rtl/alu_with_flags_8bit.sv
// Top level: input register, ALU datapath and result register with valid/ready on both sides.
// Throughput: one word per cycle while out_ready_i keeps the result register draining; a new
// word is taken while a result waits if the input register is free or advancing. The input
// register feeds the datapath into the result register.
// Reset (rst_ni low, asynchronous) empties both registers; payload is not cleared.
module alu_with_flags_8bit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  alu8f_pkg::alu_in_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output alu8f_pkg::alu_out_t out_word_o
);
  import alu8f_pkg::*;

  logic     s1_valid_q, s1_valid_d;
  alu_in_t  s1_q;
  logic     out_valid_q, out_valid_d;
  alu_out_t out_q;
  alu_out_t core_res;
  logic     out_free;
  logic     s1_adv;
  logic     in_take;

  alu8f_core u_core (
    .op_i  (s1_q),
    .res_o (core_res)
  );

  // advance when the result register is empty or being drained
  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_take    = in_valid_i && in_ready_o;

  assign s1_valid_d  = in_take || (s1_valid_q && !s1_adv);
  assign out_valid_d = s1_adv || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_q <= in_word_i;
    end
    if (s1_adv) begin
      out_q <= core_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> in_ready_o)
    else $error("input register empty but not ready");

  a_adv_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> out_valid_o)
    else $error("advanced word did not reach the result register");

  a_high_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && (s1_q.kind != OP_ADD16) |-> core_res.result[15:8] == 8'h00)
    else $error("8-bit operation produced a non-zero high byte");

  a_keep_carry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && ((s1_q.kind == OP_INC) || (s1_q.kind == OP_DEC) ||
                   (s1_q.kind == OP_BIT))
    |-> core_res.flags_out[FlagC] == s1_q.flags_in[FlagC])
    else $error("carry not kept for inc, dec or bit");

endmodule

// File: rtl/alu8f_core.sv
// Combinational datapath: one operation from an input word to a result word.
module alu8f_core (
  input  alu8f_pkg::alu_in_t  op_i,
  output alu8f_pkg::alu_out_t res_o
);
  import alu8f_pkg::*;

  logic [7:0]  a, b;
  logic        cin;
  logic        use_cin;
  logic [8:0]  add9, sub9;
  logic [4:0]  addh, subh;
  logic [7:0]  inc8, dec8;
  logic [16:0] add17;
  logic [12:0] addh13;
  logic [7:0]  r8;
  logic [15:0] res;
  logic [3:0]  fl;
  logic        z8;

  assign a       = op_i.operand_a[7:0];
  assign b       = op_i.operand_b[7:0];
  assign cin     = op_i.flags_in[FlagC];
  assign use_cin = ((op_i.kind == OP_ADC) || (op_i.kind == OP_SBC)) && cin;

  assign add9   = {1'b0, a} + {1'b0, b} + {8'd0, use_cin};
  assign addh   = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, use_cin};
  // bit 8 / bit 4 is the borrow out of the full / low nibble subtract
  assign sub9   = {1'b0, a} - {1'b0, b} - {8'd0, use_cin};
  assign subh   = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, use_cin};
  assign inc8   = b + 8'd1;
  assign dec8   = b - 8'd1;
  assign add17  = {1'b0, op_i.operand_a} + {1'b0, op_i.operand_b};
  assign addh13 = {1'b0, op_i.operand_a[11:0]} + {1'b0, op_i.operand_b[11:0]};

  always_comb begin
    r8 = a;
    unique case (op_i.kind)
      OP_ADD, OP_ADC: r8 = add9[7:0];
      OP_SUB, OP_SBC: r8 = sub9[7:0];
      OP_AND:         r8 = a & b;
      OP_XOR:         r8 = a ^ b;
      OP_OR:          r8 = a | b;
      OP_INC:         r8 = inc8;
      OP_DEC:         r8 = dec8;
      OP_RLC:         r8 = {b[6:0], b[7]};
      OP_RRC:         r8 = {b[0], b[7:1]};
      OP_RL:          r8 = {b[6:0], cin};
      OP_RR:          r8 = {cin, b[7:1]};
      OP_SLA:         r8 = {b[6:0], 1'b0};
      OP_SRA:         r8 = {b[7], b[7:1]};
      OP_SWAP:        r8 = {b[3:0], b[7:4]};
      OP_SRL:         r8 = {1'b0, b[7:1]};
      default:        r8 = a;
    endcase
  end

  assign z8 = (r8 == 8'h00);

  always_comb begin
    res = {8'h00, r8};
    fl  = op_i.flags_in;
    unique case (op_i.kind)
      OP_ADD, OP_ADC: fl = {z8, 1'b0, addh[4], add9[8]};
      OP_SUB, OP_SBC: fl = {z8, 1'b1, subh[4], sub9[8]};
      OP_CP: begin
        // flags of the subtract, accumulator passes through
        fl = {(sub9[7:0] == 8'h00), 1'b1, subh[4], sub9[8]};
      end
      OP_AND:         fl = {z8, 1'b0, 1'b1, 1'b0};
      OP_XOR, OP_OR, OP_SWAP: fl = {z8, 3'b000};
      OP_INC:         fl = {z8, 1'b0, (inc8[3:0] == 4'h0), cin};
      OP_DEC:         fl = {z8, 1'b1, (dec8[3:0] == 4'hF), cin};
      OP_ADD16: begin
        res = add17[15:0];
        fl  = {op_i.flags_in[FlagZ], 1'b0, addh13[12], add17[16]};
      end
      OP_RLC, OP_RL, OP_SLA: fl = {z8, 2'b00, b[7]};
      OP_RRC, OP_RR, OP_SRA, OP_SRL: fl = {z8, 2'b00, b[0]};
      OP_BIT:         fl = {~b[op_i.bit_index], 1'b0, 1'b1, cin};
      default:        fl = op_i.flags_in;
    endcase
  end

  assign res_o.result    = res;
  assign res_o.flags_out = fl;

endmodule

// File: dv/alu_flags_checker.sv
// Checker for the 8-bit ALU with flags: predicts each word and compares the results.
module alu_flags_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  alu8f_pkg::alu_in_t  in_word_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  alu8f_pkg::alu_out_t out_word_i,
  output int unsigned         fail_count_o,
  output int unsigned         pending_o
);

  timeunit 1ns;
  timeprecision 1ps;

  import alu8f_pkg::*;

  alu_out_t pending_results[$];

  function automatic alu_out_t alu_compute(alu_in_t w);
    logic [7:0]  a;
    logic [7:0]  b;
    logic [7:0]  r8;
    logic [8:0]  s9;
    logic [4:0]  s5;
    logic [16:0] s17;
    logic [12:0] s13;
    logic        t;
    logic        z, n, h, c;
    alu_out_t    o;
    a = w.operand_a[7:0];
    b = w.operand_b[7:0];
    o.result = {8'h00, a};
    z = w.flags_in[FlagZ];
    n = w.flags_in[FlagN];
    h = w.flags_in[FlagH];
    c = w.flags_in[FlagC];
    case (w.kind)
      OP_ADD, OP_ADC: begin
        t   = (w.kind == OP_ADC) & w.flags_in[FlagC];
        s9  = {1'b0, a} + {1'b0, b} + 9'(t);
        s5  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + 5'(t);
        o.result = {8'h00, s9[7:0]};
        z = (s9[7:0] == 8'h00);
        n = 1'b0;
        h = s5[4];
        c = s9[8];
      end
      OP_SUB, OP_SBC, OP_CP: begin
        // the sign bit of the widened difference is the borrow
        t   = (w.kind == OP_SBC) & w.flags_in[FlagC];
        s9  = {1'b0, a} - {1'b0, b} - 9'(t);
        s5  = {1'b0, a[3:0]} - {1'b0, b[3:0]} - 5'(t);
        if (w.kind != OP_CP) o.result = {8'h00, s9[7:0]};
        z = (s9[7:0] == 8'h00);
        n = 1'b1;
        h = s5[4];
        c = s9[8];
      end
      OP_AND, OP_XOR, OP_OR: begin
        if (w.kind == OP_AND) r8 = a & b;
        else if (w.kind == OP_XOR) r8 = a ^ b;
        else r8 = a | b;
        o.result = {8'h00, r8};
        z = (r8 == 8'h00);
        n = 1'b0;
        h = (w.kind == OP_AND);
        c = 1'b0;
      end
      OP_INC, OP_DEC: begin
        r8 = (w.kind == OP_INC) ? b + 8'd1 : b - 8'd1;
        o.result = {8'h00, r8};
        z = (r8 == 8'h00);
        n = (w.kind == OP_DEC);
        h = (w.kind == OP_INC) ? (r8[3:0] == 4'h0) : (r8[3:0] == 4'hF);
      end
      OP_ADD16: begin
        s17 = {1'b0, w.operand_a} + {1'b0, w.operand_b};
        s13 = {1'b0, w.operand_a[11:0]} + {1'b0, w.operand_b[11:0]};
        o.result = s17[15:0];
        n = 1'b0;
        h = s13[12];
        c = s17[16];
      end
      OP_RLC, OP_RRC, OP_RL, OP_RR, OP_SLA, OP_SRA, OP_SWAP, OP_SRL: begin
        case (w.kind)
          OP_RLC:  begin r8 = {b[6:0], b[7]};               c = b[7]; end
          OP_RRC:  begin r8 = {b[0], b[7:1]};               c = b[0]; end
          OP_RL:   begin r8 = {b[6:0], w.flags_in[FlagC]};  c = b[7]; end
          OP_RR:   begin r8 = {w.flags_in[FlagC], b[7:1]};  c = b[0]; end
          OP_SLA:  begin r8 = {b[6:0], 1'b0};               c = b[7]; end
          OP_SRA:  begin r8 = {b[7], b[7:1]};               c = b[0]; end
          OP_SWAP: begin r8 = {b[3:0], b[7:4]};             c = 1'b0; end
          default: begin r8 = {1'b0, b[7:1]};               c = b[0]; end
        endcase
        o.result = {8'h00, r8};
        z = (r8 == 8'h00);
        n = 1'b0;
        h = 1'b0;
      end
      OP_BIT: begin
        z = ~b[w.bit_index];
        n = 1'b0;
        h = 1'b1;
      end
      default: ;  // unused codes pass the low byte of A and the flags through
    endcase
    o.flags_out[FlagZ] = z;
    o.flags_out[FlagN] = n;
    o.flags_out[FlagH] = h;
    o.flags_out[FlagC] = c;
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    alu_out_t want;
    logic     bad;
    if (!rst_ni) begin
      pending_results.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      bad = 1'b0;
      // retire first: a word taken at this edge cannot come out at the same edge
      if (out_valid_i && out_ready_i) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result word %h", $time, out_word_i);
          bad = 1'b1;
        end else begin
          want = pending_results.pop_front();
          if (out_word_i.result !== want.result) begin
            $display("%0t: result expected %h got %h", $time, want.result,
                     out_word_i.result);
            bad = 1'b1;
          end
          if (out_word_i.flags_out !== want.flags_out) begin
            $display("%0t: flags expected %b got %b", $time, want.flags_out,
                     out_word_i.flags_out);
            bad = 1'b1;
          end
        end
      end
      if (in_valid_i && in_ready_i) pending_results.push_back(alu_compute(in_word_i));
      if (bad) fail_count_o <= fail_count_o + 1;
      pending_o <= pending_results.size();
    end
  end

endmodule

// File: dv/tb_top.sv
// Top of the ALU testbench: clock, reset, stimulus, back-pressure and the verdict.
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  import alu8f_pkg::*;

  localparam logic [KindW-1:0] KindSpareLo = 5'd20;
  localparam logic [KindW-1:0] KindSpareHi = 5'd31;
  localparam int unsigned      RandWords   = 1250;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  alu_in_t     in_word;
  logic        out_valid;
  logic        out_ready;
  alu_out_t    out_word;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned idle_pct;
  int unsigned stall_pct;

  alu_with_flags_8bit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_word_o  (out_word)
  );

  alu_flags_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_word_i    (in_word),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_word_i   (out_word),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic alu_in_t alu_word(logic [KindW-1:0] kind, logic [WordW-1:0] a,
                                       logic [WordW-1:0] b, logic [FlagsW-1:0] f,
                                       logic [BitIdxW-1:0] idx);
    alu_in_t w;
    w.kind      = kind;
    w.operand_a = a;
    w.operand_b = b;
    w.flags_in  = f;
    w.bit_index = idx;
    return w;
  endfunction

  // bias towards the byte values where carries and zero flags change
  function automatic logic [WordW-1:0] pick_operand();
    logic [7:0] hi;
    hi = 8'($urandom);
    case ($urandom_range(7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return {hi, 8'hFF};
      3:       return {hi, 8'h00};
      4:       return {hi, 8'h0F};
      5:       return {hi, 8'h80};
      default: return 16'($urandom);
    endcase
  endfunction

  // enter at a falling edge, leave at the falling edge after the word is taken
  task automatic send_word(alu_in_t w);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  initial begin
    logic [KindW-1:0] kind;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_word   = '0;
    idle_pct  = 31;
    stall_pct = 31;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_word(alu_word(OP_ADD,   16'hAB_FF, 16'hCD_01, 4'h0, 3'd0));
    send_word(alu_word(OP_ADC,   16'h00_0F, 16'hFF_00, 4'h1, 3'd0));
    send_word(alu_word(OP_ADC,   16'h00_FF, 16'h00_FF, 4'h1, 3'd0));
    send_word(alu_word(OP_SUB,   16'h00_00, 16'h00_01, 4'h0, 3'd0));
    send_word(alu_word(OP_SBC,   16'h00_10, 16'h00_0F, 4'h1, 3'd0));
    send_word(alu_word(OP_AND,   16'hFF_F0, 16'hFF_0F, 4'h0, 3'd0));
    send_word(alu_word(OP_XOR,   16'h12_FF, 16'h34_FF, 4'hF, 3'd0));
    send_word(alu_word(OP_OR,    16'hFF_00, 16'hFF_00, 4'hF, 3'd0));
    send_word(alu_word(OP_CP,    16'h55_3C, 16'hAA_3C, 4'h0, 3'd0));
    send_word(alu_word(OP_CP,    16'h00_00, 16'h00_FF, 4'hF, 3'd0));
    send_word(alu_word(OP_INC,   16'h00_00, 16'hFF_FF, 4'h1, 3'd0));
    send_word(alu_word(OP_DEC,   16'h00_00, 16'h00_10, 4'h0, 3'd0));
    send_word(alu_word(OP_DEC,   16'h00_00, 16'h00_01, 4'hF, 3'd0));
    send_word(alu_word(OP_ADD16, 16'hFFFF,  16'h0001,  4'h8, 3'd0));
    send_word(alu_word(OP_ADD16, 16'h0FFF,  16'h0001,  4'h7, 3'd0));
    send_word(alu_word(OP_RLC,   16'h00_00, 16'h00_80, 4'h0, 3'd0));
    send_word(alu_word(OP_RRC,   16'h00_00, 16'h00_01, 4'h0, 3'd0));
    send_word(alu_word(OP_RL,    16'h00_00, 16'h00_80, 4'h0, 3'd0));
    send_word(alu_word(OP_RR,    16'h00_00, 16'h00_01, 4'h1, 3'd0));
    send_word(alu_word(OP_SLA,   16'h00_00, 16'h00_80, 4'h0, 3'd0));
    send_word(alu_word(OP_SRA,   16'h00_00, 16'h00_81, 4'h0, 3'd0));
    send_word(alu_word(OP_SWAP,  16'h00_00, 16'hFF_F0, 4'hF, 3'd0));
    send_word(alu_word(OP_SRL,   16'h00_00, 16'h00_01, 4'h0, 3'd0));
    send_word(alu_word(OP_BIT,   16'h00_A5, 16'h00_7F, 4'h1, 3'd7));
    send_word(alu_word(OP_BIT,   16'hFF_00, 16'h00_01, 4'h0, 3'd0));
    send_word(alu_word(KindSpareLo, 16'h12_34, 16'hFFFF, 4'hA, 3'd5));
    send_word(alu_word(KindSpareHi, 16'hAB_CD, 16'h0000, 4'h5, 3'd2));

    for (int unsigned i = 0; i < RandWords; i++) begin
      // hold both sides busy through the middle stretch
      if (i >= 400 && i < 650) begin
        idle_pct  = 0;
        stall_pct = 0;
      end else begin
        idle_pct  = 31;
        stall_pct = 31;
      end
      if ($urandom_range(9) == 0) kind = 5'($urandom_range(KindSpareLo, KindSpareHi));
      else kind = 5'($urandom_range(OP_ADD, OP_BIT));
      send_word(alu_word(kind, pick_operand(), pick_operand(), 4'($urandom),
                         3'($urandom)));
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("tb_top failed");
    $finish;
  end

endmodule
